// ===== rtl/core/ddwk_pkg.sv =====
// Shared widths, reset values, codes and divider handshake types for the
// differential drive wheel kinematics block. No dependencies.
package ddwk_pkg;

  // Field and register widths.
  localparam int SPD_W  = 32;
  localparam int POS_W  = 48;
  localparam int DT_W   = 24;
  localparam int SEP_W  = 32;
  localparam int RAD_W  = 32;
  localparam int MAX_W  = 31;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register values after reset.
  localparam logic [SEP_W-1:0] SEP_RESET    = 32'd19661;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 32'd3277;
  localparam logic [MAX_W-1:0] MAX_RESET    = 31'd655360;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [1:0] REG_SEP    = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_MAX    = 2'd2;

  // Request kinds.
  typedef enum logic {OP_VELOCITY = 1'b0, OP_TICK = 1'b1} opcode_t;

  // Divider datapath width and iteration counter width.
  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = 7;

  // Quotient bits produced by the speed division and the limit scaling.
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_SPEED = 7'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_LIMIT = 7'd31;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
  } div_ctrl_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/diff_drive_wheel_kinematics_unit.sv =====
// Differential drive wheel kinematics: wheel speeds from velocity commands and
// wheel positions from ticks. Depends on ddwk_pkg and ddwk_div.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid/in_ready    opcode, velocities, elapsed time
//   out_      result     out_valid/out_ready  kind, two speeds, two positions
//   config    APB r/w    psel/penable/pwrite  separation, radius, speed limit
//
// A velocity command runs two 64-bit speed divisions on the shared restoring
// divider, then two 31-bit scaling divisions when the speed limit applies; the
// divider yields one quotient bit per cycle. A tick needs no division. Reset
// is synchronous and clears speeds and positions. A result waiting on
// out_ready stalls only the final write-back; the next request can be taken
// meanwhile.
module diff_drive_wheel_kinematics_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic signed [ddwk_pkg::SPD_W-1:0]  in_linear_velocity,
  input  logic signed [ddwk_pkg::SPD_W-1:0]  in_angular_velocity,
  input  logic [ddwk_pkg::DT_W-1:0]          in_elapsed_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_result_kind,
  output logic signed [ddwk_pkg::SPD_W-1:0]  out_left_rate,
  output logic signed [ddwk_pkg::SPD_W-1:0]  out_right_rate,
  output logic signed [ddwk_pkg::POS_W-1:0]  out_left_position,
  output logic signed [ddwk_pkg::POS_W-1:0]  out_right_position,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ddwk_pkg::ADDR_W-1:0]        paddr,
  input  logic [ddwk_pkg::DATA_W-1:0]        pwdata,
  output logic [ddwk_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import ddwk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_C_MUL, S_C_SUM, S_DIV_GO, S_DIV_WAIT, S_LIMIT, S_MUL_LO,
    S_MUL_HI, S_MUL_SUM, S_MDIV_WAIT, S_STORE, S_T_MUL, S_T_ADD, S_FINISH
  } state_t;

  // Configuration registers.
  logic [SEP_W-1:0] sep_r;
  logic [RAD_W-1:0] radius_r;
  logic [MAX_W-1:0] max_r;

  // Sequencer and operand registers.
  state_t           state_r;
  logic             side_r;
  logic             op_r;
  logic             vn_r;
  logic             wn_r;
  logic [SPD_W-1:0] vmag_r;
  logic [SPD_W-1:0] wmag_r;
  logic [DT_W-1:0]  dt_r;
  logic [DIV_W-1:0] prod_r;
  logic [DIV_W-1:0] pacc_r;
  logic [DIV_W-1:0] lnum_r;
  logic [DIV_W-1:0] rnum_r;
  logic             ln_r;
  logic             rn_r;
  logic [DIV_W-1:0] lm_r;
  logic [DIV_W-1:0] rm_r;
  logic [DIV_W-1:0] big_r;

  // Kinematic state.
  logic [SPD_W-1:0] left_rate_r;
  logic [SPD_W-1:0] right_rate_r;
  logic [POS_W-1:0] left_pos_r;
  logic [POS_W-1:0] right_pos_r;

  // Output register.
  logic             out_valid_r;
  logic             out_kind_r;
  logic [SPD_W-1:0] out_ls_r;
  logic [SPD_W-1:0] out_rs_r;
  logic [POS_W-1:0] out_lp_r;
  logic [POS_W-1:0] out_rp_r;

  // Combinational datapath.
  logic               mul_en;
  logic [SPD_W-1:0]   mul_a;
  logic [SPD_W-1:0]   mul_b;
  logic [DIV_W-1:0]   vm;
  logic               b_neg;
  logic [DIV_W-1:0]   num_nxt;
  logic               num_neg_nxt;
  logic [DIV_W-1:0]   cur_num;
  logic [DIV_W-1:0]   cur_mag;
  logic [DIV_W-1:0]   spd_q_nxt;
  logic [DIV_W-1:0]   big;
  logic               over;
  logic [2*DIV_W-1:0] psum;
  logic [SPD_W-1:0]   cur_spd;
  logic [SPD_W-1:0]   spd_mag;
  logic [DIV_W-1:0]   step_p;
  logic [POS_W-1:0]   step48;
  logic [POS_W-1:0]   pos_nxt;
  logic [SPD_W-1:0]   ls_nxt;
  logic [SPD_W-1:0]   rs_nxt;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [DIV_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_dvd;
  logic [DIV_W-1:0]   div_dsr;
  logic [DIV_W-1:0]   div_q;

  // Configuration write and read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= SEP_RESET;
      radius_r <= RADIUS_RESET;
      max_r    <= MAX_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SEP:    sep_r    <= pwdata;
        REG_RADIUS: radius_r <= pwdata;
        REG_MAX:    max_r    <= pwdata[MAX_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SEP:    prdata = sep_r;
      REG_RADIUS: prdata = radius_r;
      REG_MAX:    prdata = {1'b0, max_r};
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    cur_num = side_r ? rnum_r : lnum_r;
    cur_mag = side_r ? rm_r : lm_r;
    cur_spd = side_r ? right_rate_r : left_rate_r;
    spd_mag = cur_spd[SPD_W-1] ? (~cur_spd + SPD_W'(1)) : cur_spd;
    psum    = {32'b0, prod_r, 32'b0} + {64'b0, pacc_r};

    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    div_ctrl = '0;
    div_rem  = '0;
    div_dvd  = '0;
    div_dsr  = '0;
    unique case (state_r)
      S_C_MUL: begin
        mul_en = 1'b1;
        mul_a  = wmag_r;
        mul_b  = sep_r;
      end
      S_MUL_LO: begin
        mul_en = 1'b1;
        mul_a  = cur_mag[31:0];
        mul_b  = {1'b0, max_r};
      end
      S_MUL_HI: begin
        mul_en = 1'b1;
        mul_a  = cur_mag[63:32];
        mul_b  = {1'b0, max_r};
      end
      S_T_MUL: begin
        mul_en = 1'b1;
        mul_a  = spd_mag;
        mul_b  = {8'b0, dt_r};
      end
      S_DIV_GO: begin
        div_ctrl.start = 1'b1;
        div_ctrl.nbits = DIV_BITS_SPEED;
        div_dvd        = cur_num;
        div_dsr        = {31'b0, radius_r, 1'b0};
      end
      S_MUL_SUM: begin
        div_ctrl.start = 1'b1;
        div_ctrl.nbits = DIV_BITS_LIMIT;
        div_rem        = psum[94:31];
        div_dvd        = {psum[30:0], 33'b0};
        div_dsr        = big_r;
      end
      default: ;
    endcase
  end

  // Signed sum of the linear and turning terms for the current wheel.
  always_comb begin
    vm    = {15'b0, vmag_r, 17'b0};
    b_neg = side_r ? wn_r : ~wn_r;
    if (vn_r == b_neg) begin
      num_nxt     = vm + prod_r;
      num_neg_nxt = vn_r;
    end else if (vm >= prod_r) begin
      num_nxt     = vm - prod_r;
      num_neg_nxt = vn_r;
    end else begin
      num_nxt     = prod_r - vm;
      num_neg_nxt = b_neg;
    end
  end

  // Speed quotient, limit check, sign restore and position step.
  always_comb begin
    spd_q_nxt = (radius_r == '0 && cur_num == '0) ? '0 : div_q;
    big       = (lm_r > rm_r) ? lm_r : rm_r;
    over      = big > {33'b0, max_r};
    ls_nxt    = ln_r ? (~lm_r[31:0] + SPD_W'(1)) : lm_r[31:0];
    rs_nxt    = rn_r ? (~rm_r[31:0] + SPD_W'(1)) : rm_r[31:0];
    step_p    = cur_spd[SPD_W-1] ? (~prod_r + DIV_W'(1)) : prod_r;
    step48    = {{4{step_p[63]}}, step_p[63:20]};
    pos_nxt   = (side_r ? right_pos_r : left_pos_r) + step48;
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
      pacc_r <= prod_r;
    end
  end

  ddwk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Sequencer, kinematic state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      side_r       <= 1'b0;
      left_rate_r  <= '0;
      right_rate_r <= '0;
      left_pos_r   <= '0;
      right_pos_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one loads now.
      if (out_valid_r && out_ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_opcode;
            vn_r   <= in_linear_velocity[SPD_W-1];
            wn_r   <= in_angular_velocity[SPD_W-1];
            vmag_r <= in_linear_velocity[SPD_W-1] ?
                      (~in_linear_velocity + SPD_W'(1)) : in_linear_velocity;
            wmag_r <= in_angular_velocity[SPD_W-1] ?
                      (~in_angular_velocity + SPD_W'(1)) : in_angular_velocity;
            dt_r   <= in_elapsed_time;
            side_r <= 1'b0;
            state_r <= (in_opcode == OP_TICK) ? S_T_MUL : S_C_MUL;
          end
        end
        S_C_MUL: state_r <= S_C_SUM;
        S_C_SUM: begin
          if (side_r) begin
            rnum_r  <= num_nxt;
            rn_r    <= num_neg_nxt;
            side_r  <= 1'b0;
            state_r <= S_DIV_GO;
          end else begin
            lnum_r <= num_nxt;
            ln_r   <= num_neg_nxt;
            side_r <= 1'b1;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            if (side_r) begin
              rm_r    <= spd_q_nxt;
              side_r  <= 1'b0;
              state_r <= S_LIMIT;
            end else begin
              lm_r    <= spd_q_nxt;
              side_r  <= 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_LIMIT: begin
          big_r   <= big;
          side_r  <= 1'b0;
          state_r <= over ? S_MUL_LO : S_STORE;
        end
        S_MUL_LO:  state_r <= S_MUL_HI;
        S_MUL_HI:  state_r <= S_MUL_SUM;
        S_MUL_SUM: state_r <= S_MDIV_WAIT;
        S_MDIV_WAIT: begin
          if (div_stat.done) begin
            if (side_r) begin
              rm_r    <= div_q;
              state_r <= S_STORE;
            end else begin
              lm_r    <= div_q;
              side_r  <= 1'b1;
              state_r <= S_MUL_LO;
            end
          end
        end
        S_STORE: begin
          left_rate_r  <= ls_nxt;
          right_rate_r <= rs_nxt;
          state_r      <= S_FINISH;
        end
        S_T_MUL: state_r <= S_T_ADD;
        S_T_ADD: begin
          if (side_r) begin
            right_pos_r <= pos_nxt;
            state_r     <= S_FINISH;
          end else begin
            left_pos_r <= pos_nxt;
            side_r     <= 1'b1;
            state_r    <= S_T_MUL;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= op_r;
            out_ls_r    <= left_rate_r;
            out_rs_r    <= right_rate_r;
            out_lp_r    <= left_pos_r;
            out_rp_r    <= right_pos_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_left_rate      = out_ls_r;
  assign out_right_rate     = out_rs_r;
  assign out_left_position  = out_lp_r;
  assign out_right_position = out_rp_r;

`ifndef NO_ASSERTIONS
  // An accepted request always starts the sequencer.
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("request accepted but sequencer idle");

  // Position integration never disturbs the wheel speeds.
  a_tick_speeds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_T_ADD |=> $stable(left_rate_r) && $stable(right_rate_r))
    else $error("speed changed during tick");

  // A scaled speed never exceeds the limit.
  a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MDIV_WAIT && div_stat.done) |-> div_q <= {33'b0, max_r})
    else $error("scaled speed above limit");

  // The divider completes only while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV_WAIT || state_r == S_MDIV_WAIT))
    else $error("divider done in unexpected state");
`endif

endmodule

// ===== rtl/core/ddwk_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preloaded
// partial remainder. Depends on ddwk_pkg.
module ddwk_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ddwk_pkg::div_ctrl_t          ctrl,
  input  logic [ddwk_pkg::DIV_W-1:0]   rem_init,
  input  logic [ddwk_pkg::DIV_W-1:0]   dividend,
  input  logic [ddwk_pkg::DIV_W-1:0]   divisor,
  output ddwk_pkg::div_stat_t          stat,
  output logic [ddwk_pkg::DIV_W-1:0]   quotient
);
  import ddwk_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     sh_r;
  logic [DIV_W-1:0]     q_r;
  logic [DIV_W-1:0]     d_r;

  logic [DIV_W:0]       shifted;
  logic [DIV_W+1:0]     trial;
  logic                 ge;
  logic [DIV_W-1:0]     rem_nxt;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem_r, sh_r[DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, d_r};
    ge      = ~trial[DIV_W+1];
    rem_nxt = ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
  end

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.nbits;
        rem_r  <= rem_init;
        sh_r   <= dividend;
        d_r    <= divisor;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[DIV_W-2:0], 1'b0};
        q_r   <= {q_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

`ifndef NO_ASSERTIONS
  // A started division is in progress on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> stat.busy)
    else $error("divider did not start");

  // Completion is reported only after the iterations have stopped.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> !stat.busy)
    else $error("divider done while busy");

  // While busy there are iterations left.
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> cnt_r != '0)
    else $error("divider busy with empty count");
`endif

endmodule
